### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define HPET_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define HPET_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/hpet_pkg.sv
package hpet_pkg;

  localparam int MAX_BINS    = 64;
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int COUNT_WIDTH = 32;
  localparam int TOTAL_W     = 32;
  localparam int NB_W        = 7;
  localparam int MINS_W      = 16;
  localparam int DATA_W      = 32;
  localparam int CFG_IDX_W   = 3;

  localparam int LOG_E_W     = 5;
  localparam int FRAC_W      = 16;
  localparam int LOG_W       = LOG_E_W + FRAC_W;
  localparam int MANT_W      = 31;
  localparam int PROD_W      = COUNT_WIDTH + LOG_W;
  localparam int SUM_W       = 60;
  localparam int QUO_W       = 28;
  localparam int DVSR_W      = SUM_W + 1;
  localparam int ENT_W       = 19;
  localparam int STEP_W      = 5;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0]     TOTAL_MAX = '1;
  localparam logic [ENT_W-1:0]       ENT_MAX   = '1;

  localparam logic [DATA_W-1:0] RANGE_LOW_RST  = 32'hFFFF_0000;
  localparam logic [DATA_W-1:0] RANGE_HIGH_RST = 32'h0001_0000;
  localparam logic [DATA_W-1:0] UNIT_SPAN      = 32'h0001_0000;
  localparam logic [NB_W-1:0]   BINS_RST       = 7'd64;
  localparam logic [NB_W-1:0]   BINS_MIN       = 7'd2;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW   = 3'd0,
    REG_RANGE_HIGH  = 3'd1,
    REG_BINS_IN_USE = 3'd2,
    REG_MIN_SAMPLES = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                    start;
    logic [SUM_W-1:0]        dividend;
    logic [DVSR_W-1:0]       divisor;
    logic [STEP_W-1:0]       steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic                   start;
    logic [COUNT_WIDTH-1:0] x;
  } log_req_t;

  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] res;
  } log_rsp_t;

endpackage

### src/hpet_if.sv
interface hpet_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [hpet_pkg::DATA_W-1:0]  bias_sample;

  modport source (output valid, kind, bias_sample, input ready);
  modport sink   (input valid, kind, bias_sample, output ready);
endinterface

interface hpet_out_if;
  logic                            valid;
  logic                            ready;
  logic [hpet_pkg::BIN_W-1:0]      bin_index;
  logic [hpet_pkg::BIN_W-1:0]      top_bin;
  logic [hpet_pkg::ENT_W-1:0]      entropy;
  logic                            mode_changed;
  logic [hpet_pkg::BIN_W-1:0]      previous_peak;
  logic [hpet_pkg::TOTAL_W-1:0]    mode_change_count;
  logic [hpet_pkg::TOTAL_W-1:0]    record_count;

  modport source (output valid, bin_index, top_bin, entropy, mode_changed, previous_peak,
                  mode_change_count, record_count, input ready);
  modport sink   (input valid, bin_index, top_bin, entropy, mode_changed, previous_peak,
                  mode_change_count, record_count, output ready);
endinterface

interface hpet_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hpet_pkg::CFG_IDX_W-1:0]    index;
  logic [hpet_pkg::DATA_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/hpet_log.sv
module hpet_log (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hpet_pkg::log_req_t  req_i,
  output hpet_pkg::log_rsp_t  rsp_o
);
  import hpet_pkg::*;

  logic                 busy_q, done_q, zero_q;
  logic [STEP_W-1:0]    cnt_q;
  logic [LOG_E_W-1:0]   e_q, e_c;
  logic [MANT_W-1:0]    m_q, m_d;
  logic [FRAC_W-1:0]    frac_q;
  logic [2*MANT_W-1:0]  norm_c, sq_c;
  logic [MANT_W:0]      t_c;

  always_comb begin
    e_c = '0;
    for (int i = 0; i < COUNT_WIDTH; i++) begin
      if (req_i.x[i]) e_c = LOG_E_W'(i);
    end
    norm_c = {req_i.x, (MANT_W-1)'(0)} >> e_c;
  end

  assign sq_c = (2*MANT_W)'(m_q) * (2*MANT_W)'(m_q);
  assign t_c  = sq_c[2*MANT_W-1:MANT_W-1];
  assign m_d  = t_c[MANT_W] ? t_c[MANT_W:1] : t_c[MANT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(FRAC_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      m_q    <= norm_c[MANT_W-1:0];
      e_q    <= e_c;
      zero_q <= (req_i.x == '0);
      frac_q <= '0;
    end else if (busy_q) begin
      m_q    <= m_d;
      frac_q <= {frac_q[FRAC_W-2:0], t_c[MANT_W]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = zero_q ? '0 : {e_q, frac_q};

endmodule

### src/hpet_div.sv
module hpet_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hpet_pkg::div_req_t  req_i,
  output hpet_pkg::div_rsp_t  rsp_o
);
  import hpet_pkg::*;

  logic                busy_q, done_q;
  logic [STEP_W-1:0]   cnt_q;
  logic [SUM_W-1:0]    rem_q;
  logic [DVSR_W-1:0]   d_q;
  logic [QUO_W-1:0]    q_q;
  logic                ge_c;

  assign ge_c = DVSR_W'(rem_q) >= d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend;
      d_q   <= req_i.divisor;
      q_q   <= '0;
    end else if (busy_q) begin
      if (ge_c) rem_q <= rem_q - SUM_W'(d_q);
      d_q <= d_q >> 1;
      q_q <= {q_q[QUO_W-2:0], ge_c};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = q_q;

endmodule

### src/histogram_peak_entropy_tracker.sv
// Channel  Dir  Payload                                            Accept
// in_i     in   kind, bias_sample                                  valid & ready
// out_o    out  bin_index, top_bin, entropy, mode_changed,         valid & ready
//               previous_peak, mode_change_count, record_count
// cfg_i    in   index, data                                        valid & ready
// A record runs a 6-step bin divide, three 16-step log2 runs and a 28-step entropy
// divide; the bin divide is skipped when the sample lies outside the range. Bin counts
// sit in a 64 x 32 RAM; per-entry valid bits make clears take effect at once.
// Reset and every register write zero the statistics; cfg_i is always ready.
// in_i is taken only between items; a stalled result holds in the output register.
`include "assert_macros.svh"

module histogram_peak_entropy_tracker (
  input  logic         clk_i,
  input  logic         rst_ni,
  hpet_in_if.sink      in_i,
  hpet_out_if.source   out_o,
  hpet_cfg_if.sink     cfg_i
);
  import hpet_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_BIN  = 4'd1;
  localparam logic [3:0] ST_BDIV = 4'd2;
  localparam logic [3:0] ST_READ = 4'd3;
  localparam logic [3:0] ST_RDAT = 4'd4;
  localparam logic [3:0] ST_LOGO = 4'd5;
  localparam logic [3:0] ST_MULO = 4'd6;
  localparam logic [3:0] ST_SUB  = 4'd7;
  localparam logic [3:0] ST_LOGN = 4'd8;
  localparam logic [3:0] ST_MULN = 4'd9;
  localparam logic [3:0] ST_ADD  = 4'd10;
  localparam logic [3:0] ST_LOGT = 4'd11;
  localparam logic [3:0] ST_EDIV = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;

  logic [3:0]              state_q;
  logic [DATA_W-1:0]       lo_q, hi_q;
  logic [NB_W-1:0]         bins_q, nb_c;
  logic [MINS_W-1:0]       mins_q;

  logic [COUNT_WIDTH-1:0]  mem_q [MAX_BINS];
  logic [COUNT_WIDTH-1:0]  rd_q;
  logic [MAX_BINS-1:0]     vld_q;
  logic                    rvld_q;
  logic                    we_c;

  logic [DATA_W-1:0]       samp_q;
  logic [BIN_W-1:0]        bin_q, peak_q, prev_q;
  logic                    pvalid_q, clr_res_q, changed_q;
  logic [COUNT_WIDTH-1:0]  peak_cnt_q, cold_q, cnew_q, cold_c, cnew_c;
  logic [TOTAL_W-1:0]      total_q, chg_q, total_c;
  logic [SUM_W-1:0]        sum_q;
  logic [PROD_W-1:0]       prod_q;
  logic [LOG_W-1:0]        lg_q, lt_q;
  logic [ENT_W-1:0]        ent_q;
  logic [BIN_W-1:0]        best_c;
  logic                    better_c, changed_c;

  logic signed [DATA_W:0]  diff_s, span_s;
  logic [DATA_W-1:0]       span_c;
  logic [DATA_W+NB_W-1:0]  bprod_c;
  logic [LOG_W-1:0]        edif_c;

  logic                    acc_c, clear_c, cfg_wr_c;
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  log_req_t                log_req;
  log_rsp_t                log_rsp;

  hpet_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  hpet_log u_log (.clk_i, .rst_ni, .req_i(log_req), .rsp_o(log_rsp));

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign acc_c       = in_i.valid && in_i.ready;

  always_comb begin
    cfg_wr_c = 1'b0;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_RANGE_LOW, REG_RANGE_HIGH, REG_BINS_IN_USE, REG_MIN_SAMPLES: cfg_wr_c = 1'b1;
        default: cfg_wr_c = 1'b0;
      endcase
    end
  end

  assign clear_c = cfg_wr_c || (acc_c && in_i.kind == KIND_CLEAR);

  always_comb begin
    if (bins_q < BINS_MIN)              nb_c = BINS_MIN;
    else if (bins_q > NB_W'(MAX_BINS))  nb_c = NB_W'(MAX_BINS);
    else                                nb_c = bins_q;
    diff_s  = $signed({samp_q[DATA_W-1], samp_q}) - $signed({lo_q[DATA_W-1], lo_q});
    span_s  = $signed({hi_q[DATA_W-1], hi_q}) - $signed({lo_q[DATA_W-1], lo_q});
    span_c  = (span_s <= 0) ? UNIT_SPAN : span_s[DATA_W-1:0];
    bprod_c = (DATA_W+NB_W)'(diff_s[DATA_W-1:0]) * (DATA_W+NB_W)'(nb_c);
  end

  always_comb begin
    cold_c    = rvld_q ? rd_q : '0;
    cnew_c    = (cold_c == COUNT_MAX) ? cold_c : cold_c + COUNT_WIDTH'(1);
    total_c   = (total_q == TOTAL_MAX) ? total_q : total_q + TOTAL_W'(1);
    better_c  = (cnew_c > peak_cnt_q) || (cnew_c == peak_cnt_q && bin_q < peak_q);
    best_c    = better_c ? bin_q : peak_q;
    changed_c = (total_c >= TOTAL_W'(mins_q)) && pvalid_q && (best_c != peak_q);
    edif_c    = lt_q - div_rsp.quo[LOG_W-1:0];
  end

  always_comb begin
    div_req = '0;
    log_req = '0;
    we_c    = 1'b0;
    unique case (state_q)
      ST_BIN: begin
        if (!diff_s[DATA_W] && diff_s[DATA_W-1:0] < span_c) begin
          div_req.start    = 1'b1;
          div_req.dividend = SUM_W'(bprod_c);
          div_req.divisor  = DVSR_W'(span_c) << (BIN_W-1);
          div_req.steps    = STEP_W'(BIN_W);
        end
      end
      ST_RDAT: begin
        we_c          = 1'b1;
        log_req.start = 1'b1;
        log_req.x     = cold_c;
      end
      ST_SUB: begin
        log_req.start = 1'b1;
        log_req.x     = cnew_q;
      end
      ST_ADD: begin
        log_req.start = 1'b1;
        log_req.x     = total_q;
      end
      ST_LOGT: begin
        if (log_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = sum_q;
          div_req.divisor  = DVSR_W'(total_q) << (QUO_W-1);
          div_req.steps    = STEP_W'(QUO_W);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_c) mem_q[bin_q] <= cnew_c;
    rd_q <= mem_q[bin_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q     <= RANGE_LOW_RST;
      hi_q     <= RANGE_HIGH_RST;
      bins_q   <= BINS_RST;
      mins_q   <= '0;
    end else if (cfg_wr_c) begin
      case (cfg_i.index)
        REG_RANGE_LOW:   lo_q   <= cfg_i.data;
        REG_RANGE_HIGH:  hi_q   <= cfg_i.data;
        REG_BINS_IN_USE: bins_q <= cfg_i.data[NB_W-1:0];
        default:         mins_q <= cfg_i.data[MINS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      total_q     <= '0;
      chg_q       <= '0;
      peak_q      <= '0;
      peak_cnt_q  <= '0;
      pvalid_q    <= 1'b0;
      sum_q       <= '0;
      clr_res_q   <= 1'b0;
      out_o.valid <= 1'b0;
    end else begin
      rvld_q <= vld_q[bin_q];
      if (state_q == ST_FIN && (!out_o.valid || out_o.ready)) begin
        out_o.valid <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        out_o.valid <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (acc_c) begin
            samp_q    <= in_i.bias_sample;
            clr_res_q <= (in_i.kind == KIND_CLEAR);
            state_q   <= (in_i.kind == KIND_CLEAR) ? ST_FIN : ST_BIN;
          end
        end
        ST_BIN: begin
          if (diff_s[DATA_W]) begin
            bin_q   <= '0;
            state_q <= ST_READ;
          end else if (diff_s[DATA_W-1:0] >= span_c) begin
            bin_q   <= BIN_W'(nb_c - NB_W'(1));
            state_q <= ST_READ;
          end else begin
            state_q <= ST_BDIV;
          end
        end
        ST_BDIV: begin
          if (div_rsp.done) begin
            bin_q   <= div_rsp.quo[BIN_W-1:0];
            state_q <= ST_READ;
          end
        end
        ST_READ: state_q <= ST_RDAT;
        ST_RDAT: begin
          vld_q[bin_q] <= 1'b1;
          cold_q       <= cold_c;
          cnew_q       <= cnew_c;
          total_q      <= total_c;
          prev_q       <= peak_q;
          changed_q    <= changed_c;
          if (changed_c && chg_q != TOTAL_MAX) chg_q <= chg_q + TOTAL_W'(1);
          if (better_c) peak_cnt_q <= cnew_c;
          peak_q       <= best_c;
          pvalid_q     <= 1'b1;
          state_q      <= ST_LOGO;
        end
        ST_LOGO: begin
          if (log_rsp.done) begin
            lg_q    <= log_rsp.res;
            state_q <= ST_MULO;
          end
        end
        ST_MULO: begin
          prod_q  <= PROD_W'(cold_q) * PROD_W'(lg_q);
          state_q <= ST_SUB;
        end
        ST_SUB: begin
          sum_q   <= sum_q - SUM_W'(prod_q);
          state_q <= ST_LOGN;
        end
        ST_LOGN: begin
          if (log_rsp.done) begin
            lg_q    <= log_rsp.res;
            state_q <= ST_MULN;
          end
        end
        ST_MULN: begin
          prod_q  <= PROD_W'(cnew_q) * PROD_W'(lg_q);
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          sum_q   <= sum_q + SUM_W'(prod_q);
          state_q <= ST_LOGT;
        end
        ST_LOGT: begin
          if (log_rsp.done) begin
            lt_q    <= log_rsp.res;
            state_q <= ST_EDIV;
          end
        end
        ST_EDIV: begin
          if (div_rsp.done) begin
            if (QUO_W'(lt_q) <= div_rsp.quo)       ent_q <= '0;
            else if (edif_c > LOG_W'(ENT_MAX))     ent_q <= ENT_MAX;
            else                                   ent_q <= edif_c[ENT_W-1:0];
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_o.valid || out_o.ready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      if (clear_c) begin
        vld_q      <= '0;
        total_q    <= '0;
        chg_q      <= '0;
        peak_q     <= '0;
        peak_cnt_q <= '0;
        pvalid_q   <= 1'b0;
        sum_q      <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && (!out_o.valid || out_o.ready)) begin
      out_o.bin_index         <= clr_res_q ? '0 : bin_q;
      out_o.top_bin           <= clr_res_q ? '0 : peak_q;
      out_o.entropy           <= clr_res_q ? '0 : ent_q;
      out_o.mode_changed      <= clr_res_q ? 1'b0 : changed_q;
      out_o.previous_peak     <= clr_res_q ? '0 : prev_q;
      out_o.mode_change_count <= clr_res_q ? '0 : chg_q;
      out_o.record_count      <= clr_res_q ? '0 : total_q;
    end
  end

  `HPET_ASSERT(a_out_from_fin, $rose(out_o.valid) |-> $past(state_q == ST_FIN), "result without finish")
  `HPET_ASSERT(a_empty_zero, out_o.valid && out_o.record_count == '0 |-> out_o.entropy == '0 && out_o.top_bin == '0, "nonzero result when empty")
  `HPET_ASSERT(a_change_moves, out_o.valid && out_o.mode_changed |-> out_o.top_bin != out_o.previous_peak, "mode change without move")
  `HPET_ASSERT(a_log_owner, log_rsp.done |-> state_q == ST_LOGO || state_q == ST_LOGN || state_q == ST_LOGT, "log result unclaimed")

endmodule

### sim/histogram_peak_entropy_tracker_tb.sv
module histogram_peak_entropy_tracker_tb;
  import hpet_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 8000;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [BIN_W-1:0]   bin_index;
    logic [BIN_W-1:0]   top_bin;
    logic [ENT_W-1:0]   entropy;
    logic               mode_changed;
    logic [BIN_W-1:0]   previous_peak;
    logic [TOTAL_W-1:0] mode_change_count;
    logic [TOTAL_W-1:0] record_count;
  } hist_result_t;

  class hist_scoreboard;
    logic [DATA_W-1:0]      lo_reg;
    logic [DATA_W-1:0]      hi_reg;
    logic [NB_W-1:0]        nb_reg;
    logic [MINS_W-1:0]      min_reg;
    logic [COUNT_WIDTH-1:0] counts[MAX_BINS];
    logic [TOTAL_W-1:0]     total;
    logic [BIN_W-1:0]       peak;
    logic                   peak_seen;
    logic [TOTAL_W-1:0]     changes;
    hist_result_t           expected_q[$];
    int                     errors;

    function new();
      lo_reg = RANGE_LOW_RST;
      hi_reg = RANGE_HIGH_RST;
      nb_reg = BINS_RST;
      min_reg = '0;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (counts[i]) counts[i] = '0;
      total = '0;
      peak = '0;
      peak_seen = 1'b0;
      changes = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_RANGE_LOW:   lo_reg = val;
        REG_RANGE_HIGH:  hi_reg = val;
        REG_BINS_IN_USE: nb_reg = val[NB_W-1:0];
        REG_MIN_SAMPLES: min_reg = val[MINS_W-1:0];
        default: return;
      endcase
      wipe();
    endfunction

    function logic [63:0] log2q(logic [63:0] x);
      int e;
      logic [63:0] m;
      logic [63:0] frac;
      if (x == 0) return 0;
      e = 0;
      while (e < 63 && (x >> (e + 1)) != 0) e++;
      m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
      frac = 0;
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          frac = frac | 1;
        end
      end
      return (64'(e) << 16) | frac;
    endfunction

    function void note(logic k, logic [DATA_W-1:0] s);
      hist_result_t r;
      int nb;
      int bin;
      int best;
      longint lo, span, diff, q;
      logic [63:0] lead_count, sum, c, l, t, lt, ent;
      r = '0;
      if (k == KIND_CLEAR) begin
        wipe();
        expected_q.push_back(r);
        return;
      end
      nb = nb_reg;
      if (nb < 2) nb = 2;
      if (nb > MAX_BINS) nb = MAX_BINS;
      lo = longint'($signed(lo_reg));
      span = longint'($signed(hi_reg)) - lo;
      if (span <= 0) span = 65536;
      diff = longint'($signed(s)) - lo;
      if (diff < 0) bin = 0;
      else begin
        q = (diff * nb) / span;
        bin = (q >= nb) ? nb - 1 : int'(q);
      end
      if (counts[bin] != COUNT_MAX) counts[bin]++;
      if (total != TOTAL_MAX) total++;
      best = 0;
      lead_count = 0;
      sum = 0;
      for (int b = 0; b < nb; b++) begin
        c = 64'(counts[b]);
        if (c > lead_count) begin
          lead_count = c;
          best = b;
        end
        if (c != 0) begin
          l = log2q(c);
          if (l != 0 && c > ({64{1'b1}} / l)) t = {64{1'b1}};
          else t = c * l;
          sum = (sum > {64{1'b1}} - t) ? {64{1'b1}} : sum + t;
        end
      end
      lt = log2q(64'(total));
      sum = sum / 64'(total);
      ent = (sum >= lt) ? 0 : lt - sum;
      if (ent > 64'(ENT_MAX)) ent = 64'(ENT_MAX);
      r.previous_peak = peak;
      if (total >= 32'(min_reg) && peak_seen && BIN_W'(best) != peak) begin
        r.mode_changed = 1'b1;
        if (changes != TOTAL_MAX) changes++;
      end
      peak = BIN_W'(best);
      peak_seen = 1'b1;
      r.bin_index = BIN_W'(bin);
      r.top_bin = BIN_W'(best);
      r.entropy = ENT_W'(ent);
      r.mode_change_count = changes;
      r.record_count = total;
      expected_q.push_back(r);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %0t: %s got %0h expected %0h", $realtime, field, got, want);
      errors++;
    endtask

    task check(hist_result_t got);
      hist_result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", 64'(got), 64'd0);
        return;
      end
      want = expected_q.pop_front();
      if (got.bin_index !== want.bin_index)
        report("bin_index", 64'(got.bin_index), 64'(want.bin_index));
      if (got.top_bin !== want.top_bin)
        report("top_bin", 64'(got.top_bin), 64'(want.top_bin));
      if (got.entropy !== want.entropy)
        report("entropy", 64'(got.entropy), 64'(want.entropy));
      if (got.mode_changed !== want.mode_changed)
        report("mode_changed", 64'(got.mode_changed), 64'(want.mode_changed));
      if (got.previous_peak !== want.previous_peak)
        report("previous_peak", 64'(got.previous_peak), 64'(want.previous_peak));
      if (got.mode_change_count !== want.mode_change_count)
        report("mode_change_count", 64'(got.mode_change_count),
               64'(want.mode_change_count));
      if (got.record_count !== want.record_count)
        report("record_count", 64'(got.record_count), 64'(want.record_count));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hpet_in_if  in_if ();
  hpet_out_if out_if ();
  hpet_cfg_if cfg_if ();

  histogram_peak_entropy_tracker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  hist_scoreboard sb = new();
  int results_seen = 0;
  int idle_cycles = 0;
  bit stim_done = 0;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    hist_result_t r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      r.bin_index = out_if.bin_index;
      r.top_bin = out_if.top_bin;
      r.entropy = out_if.entropy;
      r.mode_changed = out_if.mode_changed;
      r.previous_peak = out_if.previous_peak;
      r.mode_change_count = out_if.mode_change_count;
      r.record_count = out_if.record_count;
      sb.check(r);
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    bit held;
    mode = 0;
    held = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 300) begin
        held = 1;
        out_if.ready = 1'b0;
        repeat (600) @(negedge clk_i);
      end
      if ($urandom_range(0, 150) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_if.ready = 1'b1;
        1: out_if.ready = ($urandom_range(0, 3) != 0);
        default: out_if.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic push_item(input logic k, input logic [DATA_W-1:0] s);
    @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.kind = k;
    in_if.bias_sample = s;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note(k, s);
  endtask

  task automatic hold_input(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      in_if.kind = $urandom;
      in_if.bias_sample = $urandom;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    hold_input(1);
    wait (sb.expected_q.size() == 0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic setup(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                       input logic [DATA_W-1:0] nb, input logic [DATA_W-1:0] mins);
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
    write_reg(REG_BINS_IN_USE, nb);
    write_reg(REG_MIN_SAMPLES, mins);
  endtask

  task automatic run_random(input int count);
    longint lo, span;
    logic [DATA_W-1:0] centers[3];
    logic [DATA_W-1:0] s;
    int burst;
    int sent;
    int pick;
    lo = longint'($signed(sb.lo_reg));
    span = longint'($signed(sb.hi_reg)) - lo;
    if (span <= 0) span = 65536;
    foreach (centers[i]) centers[i] = DATA_W'(lo + longint'($urandom_range(0, 32'(span - 1))));
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          s = centers[$urandom_range(0, pick % 3 == 0 ? 2 : 1)] +
              DATA_W'($urandom_range(0, 32'(span / 64)));
        end else if (pick < 85) begin
          s = DATA_W'(lo + longint'($urandom_range(0, 32'(span - 1))));
        end else begin
          s = $urandom;
        end
        if ($urandom_range(0, 99) < 3) push_item(KIND_CLEAR, $urandom);
        else push_item(KIND_RECORD, s);
        sent++;
        if ($urandom_range(0, 60) == 0) centers[$urandom_range(0, 2)] = s;
      end
      hold_input($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15));
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = KIND_RECORD;
    in_if.bias_sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_RANGE_LOW;
    cfg_if.data = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_item(KIND_RECORD, 32'h0000_0000);
    push_item(KIND_RECORD, 32'hFFFF_0000);
    push_item(KIND_RECORD, 32'hFFFE_0000);
    push_item(KIND_RECORD, 32'h0000_FFFF);
    push_item(KIND_RECORD, 32'h0001_0000);
    push_item(KIND_RECORD, 32'h7FFF_FFFF);
    push_item(KIND_RECORD, 32'h8000_0000);
    push_item(KIND_RECORD, 32'h8000_0000);
    push_item(KIND_RECORD, 32'hFFFF_FFFF);
    push_item(KIND_RECORD, 32'h5555_5555);
    push_item(KIND_RECORD, 32'hAAAA_AAAA);
    push_item(KIND_CLEAR, 32'hFFFF_FFFF);
    push_item(KIND_RECORD, 32'hFFFF_8000);
    push_item(KIND_RECORD, 32'h0000_8000);
    push_item(KIND_RECORD, 32'h0000_8000);
    push_item(KIND_RECORD, 32'hFFFF_8000);
    push_item(KIND_RECORD, 32'hFFFF_8000);
    push_item(KIND_CLEAR, 32'h0000_0000);
    push_item(KIND_RECORD, 32'h0000_4000);

    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    push_item(KIND_RECORD, 32'h0000_4000);
    setup(32'h0005_0000, 32'hFFFB_0000, 32'd0, 32'd0);
    push_item(KIND_RECORD, 32'h0005_8000);
    push_item(KIND_RECORD, 32'h0004_0000);
    run_random(80);

    setup(32'h8000_0000, 32'h7FFF_FFFF, 32'd2, 32'd0);
    run_random(100);
    setup(32'hFFFF_0000, 32'h0001_0000, 32'd127, 32'd10);
    run_random(120);
    setup(32'h0000_0000, 32'h0000_0001, 32'd64, 32'd0);
    run_random(80);
    setup(32'hFFF0_0000, 32'h0010_0000, 32'd1, 32'd65535);
    run_random(80);
    setup(32'h0000_0000, 32'h0040_0000, 32'd100, 32'd3);
    run_random(120);
    setup(32'hC000_0000, 32'h4000_0000, 32'd5, 32'd0);
    run_random(120);
    setup(32'hFFFF_0000, 32'h0001_0000, 32'd64, 32'd0);
    run_random(110);

    hold_input(1);
    wait (sb.expected_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
